[sv/qslp_pkg.sv]
// ----------------------------------------------------------------------------
// qslp_pkg
// Shared types for the last-pivot quicksort sorter: input and result words,
// the packed index range kept on the range stack and the stack command.
// ----------------------------------------------------------------------------
package qslp_pkg;

    // Width of one index inside a stacked range entry.
    localparam int RANGE_IW = 6;

    // One input word: a signed element and the flag that closes the set.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in;

    // One result word.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_res;
        logic               truncated;
    } t_out;

    // Index range still to be partitioned: low index below high index.
    typedef struct packed {
        logic [RANGE_IW-1:0] lo;
        logic [RANGE_IW-1:0] hi;
    } t_range;

    // Command from the sequencer to the range stack.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_range rng;
    } t_stack_cmd;

endpackage

[sv/quicksort_last_pivot_sorter.sv]
// ----------------------------------------------------------------------------
// quicksort_last_pivot_sorter
// Loads one word per cycle with busy low; the closing word starts an in-place
// quicksort with the last element of each range as pivot. A compare reads an
// element and then tests it; a swap writes the two elements in turn, and each
// partition also pops its range, fetches and places the pivot and stacks the
// parts. Input that is already ordered is the slowest case. Results follow at
// one word per cycle once the sort is done; the receiver cannot stall them.
// Reset is synchronous and clears control only.
module quicksort_last_pivot_sorter #(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qslp_pkg::t_in     i_item,
    output logic              o_strobe,
    output qslp_pkg::t_out    o_result
);

    localparam int AW          = $clog2(MAX_ELEMENTS);
    localparam int CW          = $clog2(MAX_ELEMENTS + 1);
    localparam int STACK_DEPTH = MAX_ELEMENTS / 2;

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_POP      = 4'd1;
    localparam logic [3:0] S_POP_WAIT = 4'd2;
    localparam logic [3:0] S_PIVOT    = 4'd3;
    localparam logic [3:0] S_I_RD     = 4'd4;
    localparam logic [3:0] S_I_CMP    = 4'd5;
    localparam logic [3:0] S_J_RD     = 4'd6;
    localparam logic [3:0] S_J_CMP    = 4'd7;
    localparam logic [3:0] S_SWAP     = 4'd8;
    localparam logic [3:0] S_FIN_RD   = 4'd9;
    localparam logic [3:0] S_FIN_HI   = 4'd10;
    localparam logic [3:0] S_FIN_I    = 4'd11;
    localparam logic [3:0] S_PUSH_HI  = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    logic [3:0]                   r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_ovf, n_ovf;
    logic [AW-1:0]                r_lo, n_lo;
    logic [AW-1:0]                r_hi, n_hi;
    logic [AW-1:0]                r_i, n_i;
    logic [AW-1:0]                r_j, n_j;
    logic signed [DATA_WIDTH-1:0] r_pivot, n_pivot;
    logic signed [DATA_WIDTH-1:0] r_ai, n_ai;
    logic                         r_pend, n_pend;
    logic                         r_olast, n_olast;
    logic                         r_otrunc, n_otrunc;

    // Memory and stack control.
    logic                         w_we;
    logic                         w_load;
    logic [AW-1:0]                w_waddr;
    logic signed [DATA_WIDTH-1:0] w_wdata;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;
    logic signed [DATA_WIDTH-1:0] w_rdata;
    qslp_pkg::t_stack_cmd         w_cmd;
    logic                         w_empty;
    qslp_pkg::t_range             w_top;

    qslp_elem_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW),
        .DW    (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_load  (w_load),
        .i_value (i_item.value),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    qslp_range_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_empty (w_empty),
        .o_top   (w_top)
    );

    // Sequencer: load, partition ranges popped from the stack, then read out.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_i      = r_i;
        n_j      = r_j;
        n_pivot  = r_pivot;
        n_ai     = r_ai;
        n_pend   = 1'b0;
        n_olast  = r_olast;
        n_otrunc = r_otrunc;
        w_we     = 1'b0;
        w_load   = 1'b0;
        w_waddr  = r_i;
        w_wdata  = r_pivot;
        w_re     = 1'b0;
        w_raddr  = r_i;
        w_cmd    = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    // Store the word while there is room, else note the drop.
                    if (r_count < CW'(MAX_ELEMENTS)) begin
                        w_we    = 1'b1;
                        w_load  = 1'b1;
                        w_waddr = r_count[AW-1:0];
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last) begin
                        n_i = '0;
                        if (n_count >= CW'(2)) begin
                            w_cmd.push   = 1'b1;
                            w_cmd.rng.lo = '0;
                            w_cmd.rng.hi = qslp_pkg::RANGE_IW'(n_count - 1'b1);
                            n_state      = S_POP;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end

            S_POP: begin
                if (w_empty) begin
                    n_i     = '0;
                    n_state = S_OUT;
                end else begin
                    w_cmd.pop = 1'b1;
                    n_state   = S_POP_WAIT;
                end
            end

            // The popped range is on the stack output; fetch its pivot.
            S_POP_WAIT: begin
                n_lo    = AW'(w_top.lo);
                n_hi    = AW'(w_top.hi);
                w_re    = 1'b1;
                w_raddr = AW'(w_top.hi);
                n_state = S_PIVOT;
            end

            S_PIVOT: begin
                n_pivot = w_rdata;
                n_i     = r_lo;
                n_j     = r_hi;
                n_state = S_I_RD;
            end

            // Left pointer advances over elements not above the pivot.
            S_I_RD: begin
                if (r_i < r_j) begin
                    w_re    = 1'b1;
                    w_raddr = r_i;
                    n_state = S_I_CMP;
                end else begin
                    n_state = S_FIN_RD;
                end
            end

            S_I_CMP: begin
                if (w_rdata <= r_pivot) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_I_RD;
                end else begin
                    n_ai    = w_rdata;
                    n_state = S_J_RD;
                end
            end

            // Right pointer retreats over elements not below the pivot.
            S_J_RD: begin
                if (r_i < r_j) begin
                    w_re    = 1'b1;
                    w_raddr = r_j;
                    n_state = S_J_CMP;
                end else begin
                    n_state = S_FIN_RD;
                end
            end

            S_J_CMP: begin
                if (w_rdata >= r_pivot) begin
                    n_j     = r_j - 1'b1;
                    n_state = S_J_RD;
                end else begin
                    // First half of the swap: the right element goes left.
                    w_we    = 1'b1;
                    w_waddr = r_i;
                    w_wdata = w_rdata;
                    n_state = S_SWAP;
                end
            end

            S_SWAP: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_ai;
                n_state = S_I_RD;
            end

            // Move the pivot into its final place at the meeting point.
            S_FIN_RD: begin
                w_re    = 1'b1;
                w_raddr = r_i;
                n_state = S_FIN_HI;
            end

            S_FIN_HI: begin
                w_we    = 1'b1;
                w_waddr = r_hi;
                w_wdata = w_rdata;
                n_state = S_FIN_I;
            end

            S_FIN_I: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_pivot;
                // Left part is stacked when it holds two or more elements.
                if ({1'b0, r_i} > ({1'b0, r_lo} + 1'b1)) begin
                    w_cmd.push   = 1'b1;
                    w_cmd.rng.lo = qslp_pkg::RANGE_IW'(r_lo);
                    w_cmd.rng.hi = qslp_pkg::RANGE_IW'(r_i - 1'b1);
                end
                n_state = S_PUSH_HI;
            end

            S_PUSH_HI: begin
                if (({1'b0, r_i} + 1'b1) < {1'b0, r_hi}) begin
                    w_cmd.push   = 1'b1;
                    w_cmd.rng.lo = qslp_pkg::RANGE_IW'(r_i + 1'b1);
                    w_cmd.rng.hi = qslp_pkg::RANGE_IW'(r_hi);
                end
                n_state = S_POP;
            end

            // Read the sorted set out, one word per cycle.
            S_OUT: begin
                w_re     = 1'b1;
                w_raddr  = r_i;
                n_pend   = 1'b1;
                n_otrunc = r_ovf;
                n_olast  = ((CW'(r_i) + 1'b1) == r_count);
                n_i      = r_i + 1'b1;
                if ((CW'(r_i) + 1'b1) == r_count) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_i      <= n_i;
        r_j      <= n_j;
        r_pivot  <= n_pivot;
        r_ai     <= n_ai;
        r_olast  <= n_olast;
        r_otrunc <= n_otrunc;
    end

    // Result word: read data is the element fetched in the previous cycle.
    assign busy                  = (r_state != S_IDLE);
    assign o_strobe              = r_pend;
    assign o_result.sorted_value = 32'(w_rdata);
    assign o_result.last_res     = r_olast;
    assign o_result.truncated    = r_otrunc;

endmodule

[sv/qslp_elem_store.sv]
// ----------------------------------------------------------------------------
// qslp_elem_store
// Element memory with one write and one registered read port. Loaded words
// are resized to the storage width here; the sequencer's swap writes pass
// straight through.
// ----------------------------------------------------------------------------
module qslp_elem_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_load,
    input  logic signed [31:0]   i_value,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [DW-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [DW-1:0] o_rdata
);

    logic signed [DW-1:0] mem [DEPTH];
    logic signed [DW-1:0] w_wdata;
    logic signed [DW-1:0] r_rdata;

    // A loaded element is sign-extended or truncated to the storage width.
    always_comb begin
        if (i_load) begin
            w_wdata = DW'(i_value);
        end else begin
            w_wdata = i_wdata;
        end
    end

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= w_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/qslp_range_stack.sv]
// ----------------------------------------------------------------------------
// qslp_range_stack
// Stack of index ranges that replaces the recursion of quicksort. Entries
// live in a memory; the top is registered on a pop and appears in the next cycle.
// ----------------------------------------------------------------------------
module qslp_range_stack #(
    parameter int DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qslp_pkg::t_stack_cmd i_cmd,
    output logic                o_empty,
    output qslp_pkg::t_range    o_top
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1);

    qslp_pkg::t_range mem [DEPTH];
    qslp_pkg::t_range r_top;
    logic [PW-1:0]    r_sp;
    logic [PW-1:0]    n_sp;
    logic [PW-1:0]    w_sp_dec;

    assign w_sp_dec = r_sp - 1'b1;

    // Stack pointer update.
    always_comb begin
        n_sp = r_sp;
        if (i_cmd.push) begin
            n_sp = r_sp + 1'b1;
        end else if (i_cmd.pop) begin
            n_sp = w_sp_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            r_sp <= n_sp;
        end
    end

    // Entry memory: push writes at the pointer, pop reads the entry below it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_sp[AW-1:0]] <= i_cmd.rng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_top <= mem[w_sp_dec[AW-1:0]];
        end
    end

    assign o_empty = (r_sp == '0);
    assign o_top   = r_top;

endmodule
